### src/dmwc_pkg.sv
// Shared types, constants and defaults for the direct-mapped write-back cache.
package dmwc_pkg;

  // Fixed field widths of a request and its response.
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned ADDR_W      = 14;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned MISS_W      = 2;
  localparam int unsigned COUNT_W     = 32;

  // Line geometry: 64-byte lines of sixteen 32-bit words.
  localparam int unsigned LINE_BYTES  = 64;
  localparam int unsigned LINE_WORDS  = 16;
  localparam int unsigned OFFSET_BITS = 6;
  localparam int unsigned BYTE_SEL_W  = 2;
  localparam int unsigned WORD_SEL_W  = OFFSET_BITS - BYTE_SEL_W;
  localparam int unsigned LINE_ADDR_W = ADDR_W - OFFSET_BITS;
  localparam int unsigned WORD_ADDR_W = ADDR_W - BYTE_SEL_W;
  localparam int unsigned CNT_W       = $clog2(LINE_WORDS + 1);

  // Default sizes for the top level.
  localparam int unsigned CACHE_BYTES_DEF  = 1024;
  localparam int unsigned MEMORY_WORDS_DEF = 4096;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_READ    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_PRELOAD = 2'd2
  } kind_e;

  // Miss classification reported with each response.
  typedef enum logic [MISS_W-1:0] {
    MISS_NONE  = 2'd0,
    MISS_COLD  = 2'd1,
    MISS_CLEAN = 2'd2,
    MISS_DIRTY = 2'd3
  } miss_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WB,
    ST_FILL,
    ST_FIN,
    ST_DONE
  } state_e;

  // Statistics events raised once per cache access.
  typedef struct packed {
    logic access;
    logic hit;
    logic miss;
  } stat_evt_t;

endpackage

### src/dmwc_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module dmwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/dmwc_stats.sv
// Access, hit and miss counters that wrap at 2^32.
module dmwc_stats (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dmwc_pkg::stat_evt_t               evt_i,
  output logic [dmwc_pkg::COUNT_W-1:0]      access_total_o,
  output logic [dmwc_pkg::COUNT_W-1:0]      hit_total_o,
  output logic [dmwc_pkg::COUNT_W-1:0]      miss_total_o
);

  logic [dmwc_pkg::COUNT_W-1:0] access_q, access_d;
  logic [dmwc_pkg::COUNT_W-1:0] hit_q, hit_d;
  logic [dmwc_pkg::COUNT_W-1:0] miss_q, miss_d;

  // Each event bumps its counter by one; overflow simply wraps.
  always_comb begin
    access_d = access_q + dmwc_pkg::COUNT_W'(evt_i.access);
    hit_d    = hit_q + dmwc_pkg::COUNT_W'(evt_i.hit);
    miss_d   = miss_q + dmwc_pkg::COUNT_W'(evt_i.miss);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_q <= '0;
      hit_q    <= '0;
      miss_q   <= '0;
    end else begin
      access_q <= access_d;
      hit_q    <= hit_d;
      miss_q   <= miss_d;
    end
  end

  assign access_total_o = access_q;
  assign hit_total_o    = hit_q;
  assign miss_total_o   = miss_q;

endmodule

### src/direct_mapped_writeback_cache.sv
// One request is in flight at a time; the line copy runs one word per cycle through the
// data and backing memory ports, so throughput follows the miss mix.
// A finished response waits in an output register while the next request is taken.
// After reset a clearing pass over all min(MEMORY_WORDS, 4096) backing words zeroes that memory and
// the line state; requests are stalled during that pass.
module direct_mapped_writeback_cache #(
  parameter int unsigned CACHE_BYTES  = dmwc_pkg::CACHE_BYTES_DEF,
  parameter int unsigned MEMORY_WORDS = dmwc_pkg::MEMORY_WORDS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dmwc_pkg::KIND_W-1:0]       kind_i,
  input  logic [dmwc_pkg::ADDR_W-1:0]       address_i,
  input  logic [dmwc_pkg::DATA_W-1:0]       write_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dmwc_pkg::DATA_W-1:0]       read_data_o,
  output logic                              hit_o,
  output logic [dmwc_pkg::MISS_W-1:0]       miss_type_o,
  output logic [dmwc_pkg::COUNT_W-1:0]      access_total_o,
  output logic [dmwc_pkg::COUNT_W-1:0]      hit_total_o,
  output logic [dmwc_pkg::COUNT_W-1:0]      miss_total_o
);

  localparam int unsigned ADDR_W      = dmwc_pkg::ADDR_W;
  localparam int unsigned DATA_W      = dmwc_pkg::DATA_W;
  localparam int unsigned OFFSET_BITS = dmwc_pkg::OFFSET_BITS;
  localparam int unsigned WORD_SEL_W  = dmwc_pkg::WORD_SEL_W;
  localparam int unsigned LINE_ADDR_W = dmwc_pkg::LINE_ADDR_W;
  localparam int unsigned WORD_ADDR_W = dmwc_pkg::WORD_ADDR_W;
  localparam int unsigned CNT_W       = dmwc_pkg::CNT_W;

  // Cache geometry.
  localparam int unsigned SHIFT       = $clog2(CACHE_BYTES + 1) - 1;
  localparam int unsigned NUM_LINES   = CACHE_BYTES / dmwc_pkg::LINE_BYTES;
  localparam int unsigned IDX_W       = $clog2(NUM_LINES);
  localparam int unsigned IDX_CMP_W   = ((LINE_ADDR_W > IDX_W) ? LINE_ADDR_W : IDX_W) + 1;
  localparam logic [ADDR_W-1:0] IMASK =
    ADDR_W'((CACHE_BYTES - 1) & ~(dmwc_pkg::LINE_BYTES - 1));
  localparam int unsigned TAG_W       = (SHIFT < ADDR_W) ? (ADDR_W - SHIFT) : 1;
  localparam int unsigned TENT_W      = TAG_W + 2;
  localparam int unsigned CDATA_DEPTH = NUM_LINES * dmwc_pkg::LINE_WORDS;
  localparam int unsigned CDATA_AW    = IDX_W + WORD_SEL_W;

  // Only word addresses below 2^WORD_ADDR_W are reachable, so backing memory stops there.
  localparam int unsigned WORD_SPAN   = 1 << WORD_ADDR_W;
  localparam int unsigned BACK_DEPTH  = (MEMORY_WORDS < WORD_SPAN) ? MEMORY_WORDS : WORD_SPAN;
  localparam int unsigned BACK_AW     = $clog2(BACK_DEPTH);
  localparam int unsigned SLOT_W      = WORD_ADDR_W + 1;
  localparam int unsigned SLOT_STEPS  = (WORD_SPAN - 1) / BACK_DEPTH;

  // Word address modulo the backing memory depth, by repeated compare and subtract.
  function automatic logic [BACK_AW-1:0] mem_slot(input logic [WORD_ADDR_W-1:0] a);
    logic [SLOT_W-1:0] v;
    v = {1'b0, a};
    for (int k = 0; k < SLOT_STEPS; k++) begin
      if (v >= SLOT_W'(BACK_DEPTH)) begin
        v = v - SLOT_W'(BACK_DEPTH);
      end
    end
    return v[BACK_AW-1:0];
  endfunction

  dmwc_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [BACK_AW-1:0]     clr_q, clr_d;
  logic [dmwc_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [ADDR_W-1:0]      addr_q, addr_d;
  logic [DATA_W-1:0]      value_q, value_d;
  logic                   hit_q, hit_d;
  dmwc_pkg::miss_e        miss_q, miss_d;
  logic [DATA_W-1:0]      rdata_q, rdata_d;
  logic [LINE_ADDR_W-1:0] vline_q, vline_d;

  // Response register.
  logic                   out_valid_q;
  logic [DATA_W-1:0]      out_data_q;
  logic                   out_hit_q;
  logic [dmwc_pkg::MISS_W-1:0] out_miss_q;
  logic [dmwc_pkg::COUNT_W-1:0] out_access_q, out_hits_q, out_misses_q;
  logic                   load_out;

  // Memory ports.
  logic                   t_we;
  logic [IDX_W-1:0]       t_waddr;
  logic [TENT_W-1:0]      t_wdata, t_rdata;
  logic                   c_we;
  logic [CDATA_AW-1:0]    c_waddr, c_raddr;
  logic [DATA_W-1:0]      c_wdata, c_rdata;
  logic                   b_we;
  logic [BACK_AW-1:0]     b_waddr, b_raddr;
  logic [DATA_W-1:0]      b_wdata, b_rdata;

  dmwc_pkg::stat_evt_t    evt;
  logic [dmwc_pkg::COUNT_W-1:0] acc_tot, hit_tot, miss_tot;

  // Address decode: the incoming request while idle, the held one otherwise.
  logic [ADDR_W-1:0]      dec_addr;
  logic [LINE_ADDR_W-1:0] idx_raw;
  logic [IDX_CMP_W-1:0]   idx_ext, idx_mod;
  logic [IDX_W-1:0]       idx;
  logic [TAG_W-1:0]       tag;
  logic [WORD_SEL_W-1:0]  word;
  logic [LINE_ADDR_W-1:0] fill_line;
  logic [ADDR_W-1:0]      vbyte;
  logic [WORD_SEL_W-1:0]  wsel;
  logic                   t_valid, t_dirty, t_match;

  always_comb begin
    dec_addr  = (state_q == dmwc_pkg::ST_IDLE) ? address_i : addr_q;
    idx_raw   = LINE_ADDR_W'((dec_addr & IMASK) >> OFFSET_BITS);
    idx_ext   = IDX_CMP_W'(idx_raw);
    idx_mod   = (idx_ext >= IDX_CMP_W'(NUM_LINES)) ? idx_ext - IDX_CMP_W'(NUM_LINES) : idx_ext;
    idx       = idx_mod[IDX_W-1:0];
    tag       = TAG_W'(dec_addr >> SHIFT);
    word      = dec_addr[OFFSET_BITS-1:dmwc_pkg::BYTE_SEL_W];
    fill_line = dec_addr[ADDR_W-1:OFFSET_BITS];
    t_valid   = t_rdata[TAG_W+1];
    t_dirty   = t_rdata[TAG_W];
    t_match   = t_valid && (t_rdata[TAG_W-1:0] == tag);
    vbyte     = (ADDR_W'(t_rdata[TAG_W-1:0]) << SHIFT) | (ADDR_W'(idx) << OFFSET_BITS);
    wsel      = WORD_SEL_W'(cnt_q - CNT_W'(1));
  end

  // Line state: {valid, dirty, tag} per line.
  dmwc_ram #(
    .WIDTH (TENT_W),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (idx),
    .rdata_o (t_rdata)
  );

  // Cached line words.
  dmwc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CDATA_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Backing memory.
  dmwc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BACK_DEPTH)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  dmwc_stats u_stats (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt_i          (evt),
    .access_total_o (acc_tot),
    .hit_total_o    (hit_tot),
    .miss_total_o   (miss_tot)
  );

  // Controller: next state, memory controls and statistics events.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    kind_d   = kind_q;
    addr_d   = addr_q;
    value_d  = value_q;
    hit_d    = hit_q;
    miss_d   = miss_q;
    rdata_d  = rdata_q;
    vline_d  = vline_q;
    t_we     = 1'b0;
    t_waddr  = idx;
    t_wdata  = '0;
    c_we     = 1'b0;
    c_waddr  = {idx, word};
    c_wdata  = value_q;
    c_raddr  = {idx, word};
    b_we     = 1'b0;
    b_waddr  = mem_slot({vline_q, wsel});
    b_wdata  = c_rdata;
    b_raddr  = mem_slot({fill_line, cnt_q[WORD_SEL_W-1:0]});
    evt      = '0;
    in_stall_o = 1'b1;
    load_out = 1'b0;

    unique case (state_q)
      dmwc_pkg::ST_CLEAR: begin
        // Zero backing memory and invalidate every line, one entry per cycle.
        b_we    = 1'b1;
        b_waddr = clr_q;
        b_wdata = '0;
        if ({1'b0, clr_q} < (BACK_AW + 1)'(NUM_LINES)) begin
          t_we    = 1'b1;
          t_waddr = IDX_W'(clr_q);
          t_wdata = '0;
        end
        if (clr_q == BACK_AW'(BACK_DEPTH - 1)) begin
          state_d = dmwc_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + BACK_AW'(1);
        end
      end

      dmwc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          kind_d  = kind_i;
          addr_d  = address_i;
          value_d = write_value_i;
          hit_d   = 1'b0;
          miss_d  = dmwc_pkg::MISS_NONE;
          rdata_d = '0;
          case (kind_i) inside
            dmwc_pkg::KIND_READ, dmwc_pkg::KIND_WRITE: begin
              state_d = dmwc_pkg::ST_LOOKUP;
            end
            dmwc_pkg::KIND_PRELOAD: begin
              b_we    = 1'b1;
              b_waddr = mem_slot(address_i[ADDR_W-1:dmwc_pkg::BYTE_SEL_W]);
              b_wdata = write_value_i;
              state_d = dmwc_pkg::ST_DONE;
            end
            default: begin
              state_d = dmwc_pkg::ST_DONE;
            end
          endcase
        end
      end

      dmwc_pkg::ST_LOOKUP: begin
        // Line state and the addressed word are both out of their memories now.
        evt.access = 1'b1;
        vline_d    = vbyte[ADDR_W-1:OFFSET_BITS];
        cnt_d      = '0;
        if (t_match) begin
          evt.hit = 1'b1;
          hit_d   = 1'b1;
          if (kind_q == dmwc_pkg::KIND_WRITE) begin
            c_we    = 1'b1;
            t_we    = 1'b1;
            t_wdata = {1'b1, 1'b1, tag};
          end else begin
            rdata_d = c_rdata;
          end
          state_d = dmwc_pkg::ST_DONE;
        end else begin
          evt.miss = 1'b1;
          if (!t_valid) begin
            miss_d  = dmwc_pkg::MISS_COLD;
            state_d = dmwc_pkg::ST_FILL;
          end else if (t_dirty) begin
            miss_d  = dmwc_pkg::MISS_DIRTY;
            state_d = dmwc_pkg::ST_WB;
          end else begin
            miss_d  = dmwc_pkg::MISS_CLEAN;
            state_d = dmwc_pkg::ST_FILL;
          end
        end
      end

      dmwc_pkg::ST_WB: begin
        // Read word n of the victim while word n-1 goes out to backing memory.
        c_raddr = {idx, cnt_q[WORD_SEL_W-1:0]};
        if (cnt_q != '0) begin
          b_we = 1'b1;
        end
        if (cnt_q == CNT_W'(dmwc_pkg::LINE_WORDS)) begin
          cnt_d   = '0;
          state_d = dmwc_pkg::ST_FILL;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      dmwc_pkg::ST_FILL: begin
        // Read word n from backing memory while word n-1 is stored in the line.
        if (cnt_q != '0) begin
          c_we    = 1'b1;
          c_waddr = {idx, wsel};
          c_wdata = b_rdata;
          if (wsel == word && kind_q == dmwc_pkg::KIND_READ) begin
            rdata_d = b_rdata;
          end
        end
        if (cnt_q == CNT_W'(dmwc_pkg::LINE_WORDS)) begin
          state_d = dmwc_pkg::ST_FIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      dmwc_pkg::ST_FIN: begin
        // Install the new tag; a write then stores its word and dirties the line.
        t_we    = 1'b1;
        t_wdata = {1'b1, (kind_q == dmwc_pkg::KIND_WRITE), tag};
        if (kind_q == dmwc_pkg::KIND_WRITE) begin
          c_we = 1'b1;
        end
        state_d = dmwc_pkg::ST_DONE;
      end

      dmwc_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = dmwc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = dmwc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmwc_pkg::ST_CLEAR;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

  // Request and working registers.
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    addr_q  <= addr_d;
    value_q <= value_d;
    hit_q   <= hit_d;
    miss_q  <= miss_d;
    rdata_q <= rdata_d;
    vline_q <= vline_d;
  end

  // Response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Response payload, with the totals as they stand after this request.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q   <= rdata_q;
      out_hit_q    <= hit_q;
      out_miss_q   <= miss_q;
      out_access_q <= acc_tot;
      out_hits_q   <= hit_tot;
      out_misses_q <= miss_tot;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_data_q;
  assign hit_o          = out_hit_q;
  assign miss_type_o    = out_miss_q;
  assign access_total_o = out_access_q;
  assign hit_total_o    = out_hits_q;
  assign miss_total_o   = out_misses_q;

`ifndef SYNTHESIS
  // Requests are never taken during the clearing pass.
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dmwc_pkg::ST_CLEAR |-> in_stall_o)
    else $error("request accepted while clearing");

  // A hit never carries a miss class.
  a_hit_no_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!hit_o || miss_type_o == dmwc_pkg::MISS_NONE))
    else $error("hit reported with a miss type");

  // Every access is counted as exactly one hit or one miss.
  a_totals_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (access_total_o == hit_total_o + miss_total_o))
    else $error("access total differs from hits plus misses");

  // A miss always continues into a writeback or a fill.
  a_miss_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmwc_pkg::ST_LOOKUP && !t_match) |=>
      (state_q == dmwc_pkg::ST_WB || state_q == dmwc_pkg::ST_FILL))
    else $error("miss did not start a line transfer");
`endif

endmodule
